// ===== rtl/spvm_pkg.sv =====
// spvm_pkg: shared constants, codes and helpers for the sample playback voice mixer
// used by every module under rtl; depends on nothing else
package spvm_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int MAX_CHANNELS = 8;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

  localparam int FUNC_W     = 2;
  localparam int LADDR_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int BLOCK_W    = 13;
  localparam int MIX_W      = 24;
  localparam int FRAME_W    = 17;
  localparam int POS_W      = 33;
  localparam int OFFSET_W   = 36;
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = BLOCK_W + STEP_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int WFRAME_W   = FRAME_W + 4;
  localparam int DIV_W      = SUM_W - FRAC_W;
  localparam int DIVCNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MIX   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPING      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED       = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEG_ADD,
    ST_BEG_WRAP_START,
    ST_BEG_WRAP_POS,
    ST_BEG_CLAMP,
    ST_MIX_FRAME,
    ST_MIX_WRAP,
    ST_MIX_READ,
    ST_MIX_OUT
  } state_t;

  function automatic logic [CNT_W-1:0] clamp_ch(input logic [3:0] c);
    logic [CNT_W-1:0] r;
    if (c == 4'd0) begin
      r = CNT_W'(1);
    end else if (int'(c) > MAX_CHANNELS) begin
      r = CNT_W'(MAX_CHANNELS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage

// ===== rtl/spvm_sample_ram.sv =====
// spvm_sample_ram: single-port-write sample memory with a registered read
// depends on spvm_pkg for depth and word width
module spvm_sample_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [spvm_pkg::ADDR_W-1:0]    waddr,
  input  logic [spvm_pkg::SAMPLE_W-1:0]  wdata,
  input  logic                           re,
  input  logic [spvm_pkg::ADDR_W-1:0]    raddr,
  output logic [spvm_pkg::SAMPLE_W-1:0]  rdata
);
  import spvm_pkg::*;

  logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spvm_rem_unit.sv =====
// spvm_rem_unit: restoring remainder unit, one dividend bit per cycle
// depends on spvm_pkg for dividend and divisor widths
module spvm_rem_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spvm_pkg::DIV_W-1:0]    dividend,
  input  logic [spvm_pkg::FRAME_W-1:0]  divisor,
  output logic                          done,
  output logic [spvm_pkg::FRAME_W-1:0]  rem
);
  import spvm_pkg::*;

  logic                busy;
  logic [DIVCNT_W-1:0] cnt;
  logic [DIV_W-1:0]    dvd;
  logic [FRAME_W-1:0]  dsr;
  logic [FRAME_W:0]    try_val;
  logic [FRAME_W:0]    diff;
  logic                fits;

  assign try_val = {rem, dvd[DIV_W-1]};
  assign diff    = try_val - {1'b0, dsr};
  assign fits    = (try_val >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIVCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIVCNT_W'(1);
        if (cnt == DIVCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= fits ? diff[FRAME_W-1:0] : try_val[FRAME_W-1:0];
    end
  end

endmodule

// ===== rtl/sample_playback_voice_mixer_unit.sv =====
// sample_playback_voice_mixer_unit: one playback voice, nearest-sample resampling into a mix
// load and unused words go back to idle; begin words add block_frames*step to the position and
// clamp it to the source end, or wrap it by two serial remainders when looping over a source;
// paused or finished begin words change nothing; mix words find the frame, wrap it if looping,
// read the sample and add it with saturation; pass-through and finishing mix words return mix_in
// reset: config registers to defaults, position state cleared, sample memory undefined, no clear pass
module sample_playback_voice_mixer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spvm_pkg::FUNC_W-1:0]       func,
  input  logic [spvm_pkg::LADDR_W-1:0]      load_addr,
  input  logic signed [spvm_pkg::SAMPLE_W-1:0] load_value,
  input  logic [spvm_pkg::BLOCK_W-1:0]      block_frames,
  input  logic signed [spvm_pkg::MIX_W-1:0] mix_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [spvm_pkg::MIX_W-1:0] mix_out,
  output logic                              done_res,
  input  logic                              cfg_write,
  input  logic [spvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spvm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spvm_pkg::*;

  state_t state, state_next;

  logic [3:0]          src_channels;
  logic [3:0]          out_channels;
  logic [FRAME_W-1:0]  frame_total;
  logic [STEP_W-1:0]   step;
  logic                looping;
  logic                paused;

  logic [POS_W-1:0]    play_position;
  logic [FRAME_W-1:0]  block_start;
  logic [OFFSET_W-1:0] frame_offset;
  logic [CH_W-1:0]     channel_index;
  logic                finished;
  logic                mix_play;

  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        pos_sum;
  logic signed [MIX_W-1:0] mix_q;
  logic [FRAME_W-1:0]      frame_q;

  logic                in_acc;
  logic                wrap_on;
  logic                out_free;
  logic [POS_W-1:0]    end_pos;
  logic [WFRAME_W-1:0] frame_w;
  logic                past_end;
  logic [CNT_W-1:0]    sc;
  logic [CNT_W-1:0]    oc;
  logic [CNT_W-1:0]    ci_ext;
  logic [CNT_W-1:0]    ci_inc;
  logic [CNT_W-1:0]    src_ch;
  localparam int AFULL_W = WFRAME_W + CNT_W;
  logic [AFULL_W-1:0]  addr_full;
  logic [OFFSET_W:0]   off_sum;
  logic [OFFSET_W-1:0] off_next;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic                div_done;
  logic [FRAME_W-1:0]  div_rem;

  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0]     ram_rdata;
  logic [MIX_W:0]          sum_w;
  logic signed [MIX_W-1:0] sat_sum;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wrap_on  = looping && (frame_total != '0);
  assign out_free = !out_valid || !out_stall;
  assign end_pos  = {frame_total, {FRAC_W{1'b0}}};
  assign frame_w  = WFRAME_W'(block_start) + WFRAME_W'(frame_offset[OFFSET_W-1:FRAC_W]);
  assign past_end = (frame_w >= WFRAME_W'(frame_total));

  assign sc        = clamp_ch(src_channels);
  assign oc        = clamp_ch(out_channels);
  assign ci_ext    = CNT_W'(channel_index);
  assign ci_inc    = ci_ext + CNT_W'(1);
  assign src_ch    = (ci_ext < sc) ? ci_ext : (sc - CNT_W'(1));
  assign addr_full = AFULL_W'(frame_q) * AFULL_W'(sc) + AFULL_W'(src_ch);
  assign off_sum   = (OFFSET_W + 1)'(frame_offset) + (OFFSET_W + 1)'(step);
  assign off_next  = off_sum[OFFSET_W] ? {OFFSET_W{1'b1}} : off_sum[OFFSET_W-1:0];

  assign ram_we    = in_acc && (func == FUNC_LOAD);
  assign ram_waddr = ADDR_W'(load_addr);
  assign ram_raddr = ADDR_W'(addr_full);

  assign sum_w   = {mix_q[MIX_W-1], mix_q}
                 + {{(MIX_W + 1 - SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
  assign sat_sum = (sum_w[MIX_W] != sum_w[MIX_W-1])
                 ? {sum_w[MIX_W], {(MIX_W - 1){~sum_w[MIX_W]}}}
                 : sum_w[MIX_W-1:0];

  spvm_sample_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (load_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spvm_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_total),
    .done     (div_done),
    .rem      (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_channels <= 4'd1;
      out_channels <= 4'd2;
      frame_total  <= '0;
      step         <= STEP_W'(65536);
      looping      <= 1'b0;
      paused       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SRC_CHANNELS: src_channels <= cfg_data[3:0];
        REG_OUT_CHANNELS: out_channels <= cfg_data[3:0];
        REG_FRAME_TOTAL:  frame_total  <= cfg_data[FRAME_W-1:0];
        REG_STEP:         step         <= cfg_data[STEP_W-1:0];
        REG_LOOPING:      looping      <= cfg_data[0];
        REG_PAUSED:       paused       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    ram_re       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_BEGIN: begin
              if (!paused && !finished) state_next = ST_BEG_ADD;
            end
            FUNC_MIX: begin
              if (!paused && !finished && (frame_total != '0)) state_next = ST_MIX_FRAME;
              else state_next = ST_MIX_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_BEG_ADD: begin
        if (wrap_on) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(play_position[POS_W-1:FRAC_W]);
          state_next   = ST_BEG_WRAP_START;
        end else begin
          state_next = ST_BEG_CLAMP;
        end
      end
      ST_BEG_WRAP_START: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = pos_sum[SUM_W-1:FRAC_W];
          state_next   = ST_BEG_WRAP_POS;
        end
      end
      ST_BEG_WRAP_POS: begin
        if (div_done) state_next = ST_IDLE;
      end
      ST_BEG_CLAMP: state_next = ST_IDLE;
      ST_MIX_FRAME: begin
        if (past_end) begin
          if (looping) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(frame_w);
            state_next   = ST_MIX_WRAP;
          end else begin
            state_next = ST_MIX_OUT;
          end
        end else begin
          state_next = ST_MIX_READ;
        end
      end
      ST_MIX_WRAP: begin
        if (div_done) state_next = ST_MIX_READ;
      end
      ST_MIX_READ: begin
        ram_re     = 1'b1;
        state_next = ST_MIX_OUT;
      end
      ST_MIX_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      block_start   <= '0;
      frame_offset  <= '0;
      channel_index <= '0;
      finished      <= 1'b0;
      mix_play      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) mix_play <= !paused && !finished && (frame_total != '0);
        end
        ST_BEG_ADD: begin
          frame_offset  <= '0;
          channel_index <= '0;
          if (!wrap_on) block_start <= play_position[POS_W-1:FRAC_W];
        end
        ST_BEG_WRAP_START: begin
          if (div_done) block_start <= div_rem;
        end
        ST_BEG_WRAP_POS: begin
          if (div_done) play_position <= {div_rem, pos_sum[FRAC_W-1:0]};
        end
        ST_BEG_CLAMP: begin
          play_position <= (pos_sum > SUM_W'(end_pos)) ? end_pos : pos_sum[POS_W-1:0];
        end
        ST_MIX_FRAME: begin
          if (past_end && !looping) begin
            finished <= 1'b1;
            mix_play <= 1'b0;
          end
        end
        ST_MIX_READ: begin
          if (ci_inc >= oc) begin
            channel_index <= '0;
            frame_offset  <= off_next;
          end else begin
            channel_index <= ci_inc[CH_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_MIX_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          prod  <= PROD_W'(block_frames) * PROD_W'(step);
          mix_q <= mix_in;
        end
      end
      ST_BEG_ADD: pos_sum <= SUM_W'(play_position) + SUM_W'(prod);
      ST_MIX_FRAME: begin
        if (!past_end) frame_q <= frame_w[FRAME_W-1:0];
      end
      ST_MIX_WRAP: begin
        if (div_done) frame_q <= div_rem;
      end
      ST_MIX_OUT: begin
        if (out_free) begin
          mix_out  <= mix_play ? sat_sum : mix_q;
          done_res <= finished;
        end
      end
      default: ;
    endcase
  end

endmodule
